[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the key matrix injector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, skipped while reset is active.
`define KMI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The same check with an implication written out by the caller.
`define KMI_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

[rtl/core/kmi_pkg.sv]
// ----------------------------------------------------------------------------
// kmi_pkg
// Types and constants shared by the key matrix injector modules.
// ----------------------------------------------------------------------------
package kmi_pkg;

  // Width of the reported matrix and of a key index.
  localparam int unsigned MATRIX_W  = 40;
  localparam int unsigned KEY_IDX_W = 6;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_HOST_DOWN   = 3'd1,
    CMD_HOST_UP     = 3'd2,
    CMD_PULSE       = 3'd3,
    CMD_RELEASE_ALL = 3'd4
  } cmd_e;

  // Configuration register indexes.
  localparam logic [2:0] CFG_RELEASE_HOLD = 3'd0;
  localparam logic [2:0] CFG_PULSE_FRAMES = 3'd1;
  localparam logic [2:0] CFG_GAP_FRAMES   = 3'd2;
  localparam logic [2:0] CFG_SHIFT_ROW    = 3'd3;
  localparam logic [2:0] CFG_SHIFT_COL    = 3'd4;

  // Control states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PULSE,
    ST_WALK,
    ST_DONE
  } state_e;

  // One queued or active pulse key.
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       shift;
  } pulse_ent_t;

  // A single set or clear of one matrix bit.
  typedef struct packed {
    logic                 en;
    logic                 set;
    logic [KEY_IDX_W-1:0] idx;
  } bit_op_t;

  // Pulse unit controls driven by the sequencer.
  typedef struct packed {
    logic       tick_rd;
    logic       tick_step;
    logic       push;
    logic       clear;
    pulse_ent_t ent;
  } pulse_ctl_t;

endpackage

[rtl/core/kmi_key_walk.sv]
// ----------------------------------------------------------------------------
// kmi_key_walk
// Per-key hold state memory and the sequential hold counter walk.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmi_key_walk import kmi_pkg::*; #(
  parameter int unsigned NKEYS = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 host_we_i,
  input  logic                 host_down_i,
  input  logic [KEY_IDX_W-1:0] host_idx_i,
  input  logic [7:0]           release_frames_i,
  input  logic                 walk_start_i,
  input  logic                 clear_i,
  output bit_op_t              op_o,
  output logic                 done_o
);

  localparam int unsigned KW = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam logic [KW-1:0] LAST = KW'(NKEYS - 1);

  // Entry: held mark over the release hold counter.
  logic [8:0]       mem [NKEYS];
  logic [NKEYS-1:0] vld_q;

  logic          run_q;
  logic [KW-1:0] iss_idx_q;
  logic          p_vld_q;
  logic [KW-1:0] p_idx_q;
  logic [8:0]    rd_q;
  logic          rd_vld_q;

  logic          held;
  logic [7:0]    cnt;
  logic [7:0]    cnt_dec;
  logic          wb_we;
  logic          we;
  logic [KW-1:0] wa;
  logic [8:0]    wd;

  // Entries never written since reset or release all read as released.
  assign held    = rd_vld_q & rd_q[8];
  assign cnt     = rd_vld_q ? rd_q[7:0] : 8'd0;
  assign cnt_dec = cnt - 8'd1;

  // Write-back of the walked entry, or a host event.
  always_comb begin
    wb_we = p_vld_q && !held && (cnt != 8'd0);
    op_o  = '0;
    if (p_vld_q) begin
      op_o.idx = KEY_IDX_W'(p_idx_q);
      if (held) begin
        op_o.en  = 1'b1;
        op_o.set = 1'b1;
      end else if (cnt == 8'd1) begin
        op_o.en  = 1'b1;
        op_o.set = 1'b0;
      end
    end
    we = wb_we || host_we_i;
    if (host_we_i) begin
      wa = host_idx_i[KW-1:0];
      wd = {host_down_i, host_down_i ? 8'd0 : release_frames_i};
    end else begin
      wa = p_idx_q;
      wd = {1'b0, cnt_dec};
    end
  end

  assign done_o = p_vld_q && (p_idx_q == LAST);

  // Key state memory, one read and one write a cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[iss_idx_q];
  end

  // Valid marks and walk sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      run_q     <= 1'b0;
      iss_idx_q <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[wa] <= 1'b1;
      end
      rd_vld_q <= vld_q[iss_idx_q];
      p_vld_q  <= run_q;
      p_idx_q  <= iss_idx_q;
      if (walk_start_i) begin
        run_q     <= 1'b1;
        iss_idx_q <= '0;
      end else if (run_q) begin
        if (iss_idx_q == LAST) begin
          run_q <= 1'b0;
        end else begin
          iss_idx_q <= iss_idx_q + KW'(1);
        end
      end
    end
  end

  // A host write never lands during a walk write-back.
  `KMI_ASSERT(a_no_wr_overlap, clk_i, rst_ni, !(host_we_i && p_vld_q), "host write during walk")

endmodule

[rtl/core/kmi_pulse_queue.sv]
// ----------------------------------------------------------------------------
// kmi_pulse_queue
// Typed key pulse timer, inter-pulse gap and the ring queue of pending pulses.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmi_pulse_queue import kmi_pkg::*; #(
  parameter int unsigned ROWS        = 8,
  parameter int unsigned COLS        = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pulse_ctl_t ctl_i,
  input  logic [7:0] pulse_frames_i,
  input  logic [7:0] gap_frames_i,
  input  logic [2:0] shift_row_i,
  input  logic [2:0] shift_col_i,
  output logic       push_ok_o,
  output logic       pending_o,
  output bit_op_t    key_op_o,
  output bit_op_t    shift_op_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam logic [QW-1:0] QLAST = QW'(QUEUE_DEPTH - 1);

  pulse_ent_t ring [QUEUE_DEPTH];
  pulse_ent_t ring_rd_q;

  logic [QW-1:0] head_q, head_d, tail_q, tail_d, tail_inc;
  logic          on_q, on_d;
  pulse_ent_t    act_q, act_d;
  logic [7:0]    left_q, left_d, left_n;
  logic [7:0]    gap_q, gap_d;

  logic          empty, full, idle, ring_we, do_start;
  pulse_ent_t    ent;
  logic          shift_ok, ent_ok;
  logic [KEY_IDX_W-1:0] shift_idx, ent_idx;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    ptr_inc = (p == QLAST) ? '0 : p + QW'(1);
  endfunction

  assign tail_inc = ptr_inc(tail_q);
  assign empty    = (head_q == tail_q);
  assign full     = (tail_inc == head_q);
  assign idle     = !on_q && (gap_q == 8'd0) && empty;
  assign push_ok_o = idle || !full;
  assign pending_o = on_q || (gap_q != 8'd0) || !empty;

  // Shift key position, used only when it lies inside the matrix.
  assign shift_ok  = (shift_row_i < ROWS) && (shift_col_i < COLS);
  assign shift_idx = KEY_IDX_W'(shift_row_i * COLS + shift_col_i);

  // Pulse start, end and queue bookkeeping.
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    on_d     = on_q;
    act_d    = act_q;
    left_d   = left_q;
    gap_d    = gap_q;
    ring_we  = 1'b0;
    do_start = 1'b0;
    ent      = act_q;
    key_op_o   = '0;
    shift_op_o = '0;
    left_n   = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;

    if (ctl_i.clear) begin
      on_d   = 1'b0;
      gap_d  = 8'd0;
      head_d = '0;
      tail_d = '0;
    end else if (ctl_i.push) begin
      if (idle) begin
        do_start = 1'b1;
        ent      = ctl_i.ent;
      end else if (!full) begin
        ring_we = 1'b1;
        tail_d  = tail_inc;
      end
    end else if (ctl_i.tick_step) begin
      if (gap_q != 8'd0) begin
        gap_d = gap_q - 8'd1;
        if ((gap_q == 8'd1) && !empty) begin
          head_d   = ptr_inc(head_q);
          do_start = 1'b1;
          ent      = ring_rd_q;
        end
      end else if (on_q) begin
        left_d = left_n;
        if (left_n == 8'd0) begin
          on_d = 1'b0;
          if (!empty) begin
            gap_d = gap_frames_i;
          end
        end
      end
    end

    ent_ok  = (ent.row < ROWS) && (ent.col < COLS);
    ent_idx = KEY_IDX_W'(ent.row * COLS + ent.col);

    if (do_start) begin
      act_d  = ent;
      on_d   = 1'b1;
      left_d = pulse_frames_i;
    end

    // Start sets the pulse bits; the end of a pulse clears them.
    if (do_start || (on_q && !on_d && !ctl_i.clear)) begin
      key_op_o.en    = ent_ok;
      key_op_o.set   = do_start;
      key_op_o.idx   = ent_idx;
      shift_op_o.en  = ent.shift && shift_ok;
      shift_op_o.set = do_start;
      shift_op_o.idx = shift_idx;
    end
  end

  // Ring storage: written at the tail, head read into a register in the cycle before its use.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring[tail_q] <= ctl_i.ent;
    end
    if (ctl_i.tick_rd) begin
      ring_rd_q <= ring[head_q];
    end
  end

  // Control and timer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      on_q   <= 1'b0;
      act_q  <= '0;
      left_q <= 8'd0;
      gap_q  <= 8'd0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      on_q   <= on_d;
      act_q  <= act_d;
      left_q <= left_d;
      gap_q  <= gap_d;
    end
  end

  // A gap only runs between pulses, never during one.
  `KMI_ASSERT(a_gap_excl, clk_i, rst_ni, !(on_q && (gap_q != 8'd0)), "gap while pulse active")
  // A queued pulse is only taken on a tick step.
  `KMI_ASSERT(a_head_move, clk_i, rst_ni,
    (head_d == head_q) || ctl_i.tick_step || ctl_i.clear, "head moved outside tick")

endmodule

[rtl/core/key_matrix_injector_with_typing_queue.sv]
// ----------------------------------------------------------------------------
// key_matrix_injector_with_typing_queue
// Emulated key matrix driven by host key events and a queue of typed pulses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command item: frame
//   tick, host key down, host key up, typed pulse key or release all.
//   Output channel (out_valid_o / out_ready_i) returns one result item per
//   command: the matrix after the command, an accepted flag and pending.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once; the user makes them only while no item is in flight (not enforced).
//   A key, pulse or release-all command passes from the DONE state into the
//   output register; a frame tick first runs the pulse step and then the walk
//   through the key state memory, which reads and writes back one key a
//   cycle, before it reaches the DONE state.
//   The sequencer takes only one item at a time: the next item is taken in
//   the cycle after the result is loaded.
//   A new item is accepted whenever the sequencer is idle, also while the
//   previous result still waits in the output register; if the receiver
//   stalls, the next result waits in the sequencer until that register frees.
//   Reset clears the matrix, all hold state, the pulse timer and the queue,
//   and loads the register defaults; the block is ready on the first cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module key_matrix_injector_with_typing_queue import kmi_pkg::*; #(
  parameter int unsigned ROWS        = 8,
  parameter int unsigned COLS        = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          cmd_i,
  input  logic [2:0]          row_i,
  input  logic [2:0]          col_i,
  input  logic                with_shift_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MATRIX_W-1:0] matrix_o,
  output logic                accepted_o,
  output logic                pending_o
);

  localparam int unsigned NKEYS = ROWS * COLS;
  localparam int unsigned KW    = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  // Configuration registers.
  logic [7:0] rel_hold_q, pulse_frames_q, gap_frames_q;
  logic [2:0] shift_row_q, shift_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_hold_q     <= 8'd2;
      pulse_frames_q <= 8'd4;
      gap_frames_q   <= 8'd2;
      shift_row_q    <= 3'd0;
      shift_col_q    <= 3'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RELEASE_HOLD: rel_hold_q     <= cfg_wdata_i;
        CFG_PULSE_FRAMES: pulse_frames_q <= cfg_wdata_i;
        CFG_GAP_FRAMES:   gap_frames_q   <= cfg_wdata_i;
        CFG_SHIFT_ROW:    shift_row_q    <= cfg_wdata_i[2:0];
        CFG_SHIFT_COL:    shift_col_q    <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  state_e     state_q, state_d;
  logic [NKEYS-1:0] matrix_q, matrix_d;
  logic       acc_q, acc_d;
  logic       out_vld_q;
  logic [MATRIX_W-1:0] out_mat_q;
  logic       out_acc_q, out_pend_q;

  logic       in_acc, key_ok, host_we, walk_start, walk_done, out_load;
  logic [KEY_IDX_W-1:0] key_idx;
  pulse_ctl_t pctl;
  logic       push_ok, pending;
  bit_op_t    pkey_op, pshift_op, walk_op;
  logic [MATRIX_W-1:0] mat_rep;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign key_ok     = (row_i < ROWS) && (col_i < COLS);
  assign key_idx    = KEY_IDX_W'(row_i * COLS + col_i);
  assign out_load   = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);

  // Sequencer: decode the command, run the tick, hand off the result.
  always_comb begin
    state_d    = state_q;
    acc_d      = acc_q;
    host_we    = 1'b0;
    walk_start = 1'b0;
    pctl       = '0;
    pctl.ent   = '{row: row_i, col: col_i, shift: with_shift_i};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DONE;
          acc_d   = 1'b0;
          unique case (cmd_e'(cmd_i))
            CMD_TICK: begin
              pctl.tick_rd = 1'b1;
              acc_d        = 1'b1;
              state_d      = ST_PULSE;
            end
            CMD_HOST_DOWN, CMD_HOST_UP: begin
              host_we = key_ok;
              acc_d   = key_ok;
            end
            CMD_PULSE: begin
              pctl.push = key_ok;
              acc_d     = key_ok && push_ok;
            end
            CMD_RELEASE_ALL: begin
              pctl.clear = 1'b1;
              acc_d      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_PULSE: begin
        pctl.tick_step = 1'b1;
        walk_start     = 1'b1;
        state_d        = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Matrix update: host down, pulse bits, then the walk; release all clears it.
  always_comb begin
    matrix_d = matrix_q;
    if (host_we && (cmd_e'(cmd_i) == CMD_HOST_DOWN)) begin
      matrix_d[key_idx[KW-1:0]] = 1'b1;
    end
    if (pkey_op.en) begin
      matrix_d[pkey_op.idx[KW-1:0]] = pkey_op.set;
    end
    if (pshift_op.en) begin
      matrix_d[pshift_op.idx[KW-1:0]] = pshift_op.set;
    end
    if (walk_op.en) begin
      matrix_d[walk_op.idx[KW-1:0]] = walk_op.set;
    end
    if (pctl.clear) begin
      matrix_d = '0;
    end
  end

  // Report the low matrix bits, zero padded when the matrix is small.
  generate
    if (NKEYS >= MATRIX_W) begin : g_mat_cut
      assign mat_rep = matrix_q[MATRIX_W-1:0];
    end else begin : g_mat_pad
      assign mat_rep = {{(MATRIX_W - NKEYS){1'b0}}, matrix_q};
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      matrix_q  <= '0;
      acc_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      matrix_q <= matrix_d;
      acc_q    <= acc_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Output item register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mat_q  <= mat_rep;
      out_acc_q  <= acc_q;
      out_pend_q <= pending;
    end
  end

  assign out_valid_o = out_vld_q;
  assign matrix_o    = out_mat_q;
  assign accepted_o  = out_acc_q;
  assign pending_o   = out_pend_q;

  kmi_key_walk #(
    .NKEYS(NKEYS)
  ) u_walk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .host_we_i        (host_we),
    .host_down_i      (cmd_e'(cmd_i) == CMD_HOST_DOWN),
    .host_idx_i       (key_idx),
    .release_frames_i (rel_hold_q),
    .walk_start_i     (walk_start),
    .clear_i          (pctl.clear),
    .op_o             (walk_op),
    .done_o           (walk_done)
  );

  kmi_pulse_queue #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_pulse (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (pctl),
    .pulse_frames_i (pulse_frames_q),
    .gap_frames_i   (gap_frames_q),
    .shift_row_i    (shift_row_q),
    .shift_col_i    (shift_col_q),
    .push_ok_o      (push_ok),
    .pending_o      (pending),
    .key_op_o       (pkey_op),
    .shift_op_o     (pshift_op)
  );

  // An accepted tick always runs the pulse step next.
  `KMI_ASSERT_IMPL(a_tick_seq, clk_i, rst_ni, in_acc && (cmd_i == CMD_TICK),
    state_q == ST_PULSE, "tick did not start pulse step")
  // The walk only finishes while the sequencer waits for it.
  `KMI_ASSERT(a_walk_done, clk_i, rst_ni, !walk_done || (state_q == ST_WALK),
    "walk finished outside walk state")

endmodule
